// ===== sv/rsfe_pkg.sv =====
`default_nettype none

package rsfe_pkg;

  // Frame size defaults
  localparam int FRAME_WIDTH_DEF  = 128;
  localparam int FRAME_HEIGHT_DEF = 128;

  // Field widths fixed by the command format
  localparam int MODE_W  = 3;
  localparam int COORD_W = 10;
  localparam int PIXEL_W = 32;
  localparam int RSQ_W   = 2 * COORD_W;

  // Command queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLOT  = 3'd0,
    MODE_RECT  = 3'd1,
    MODE_DISC  = 3'd2,
    MODE_CLEAR = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_FILL,
    JOB_DISC,
    JOB_READ
  } job_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } back_state_t;

  // Classified command: clipped, inclusive bounds of the area to walk
  typedef struct packed {
    job_kind_t            kind;
    logic [COORD_W-1:0]   x_lo;
    logic [COORD_W-1:0]   x_hi;
    logic [COORD_W-1:0]   y_lo;
    logic [COORD_W-1:0]   y_hi;
    logic [COORD_W-1:0]   cx;
    logic [COORD_W-1:0]   cy;
    logic [RSQ_W-1:0]     r2;
    logic [PIXEL_W-1:0]   paint;
  } job_t;

endpackage

`default_nettype wire

// ===== sv/rsfe_if.sv =====
`default_nettype none

interface rsfe_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [rsfe_pkg::MODE_W-1:0]   mode;
  logic [rsfe_pkg::COORD_W-1:0]  x_coord;
  logic [rsfe_pkg::COORD_W-1:0]  y_coord;
  logic [rsfe_pkg::COORD_W-1:0]  span_width;
  logic [rsfe_pkg::COORD_W-1:0]  span_height;
  logic [rsfe_pkg::PIXEL_W-1:0]  paint;

  modport source (
    output valid, mode, x_coord, y_coord, span_width, span_height, paint,
    input  ready
  );
  modport sink (
    input  valid, mode, x_coord, y_coord, span_width, span_height, paint,
    output ready
  );
endinterface

interface rsfe_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rsfe_pkg::PIXEL_W-1:0]  read_pixel;
  logic                          read_hit;

  modport source (
    output valid, read_pixel, read_hit,
    input  ready
  );
  modport sink (
    input  valid, read_pixel, read_hit,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/rsfe_front.sv =====
`default_nettype none

module rsfe_front #(
  parameter int FRAME_WIDTH  = rsfe_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rsfe_pkg::FRAME_HEIGHT_DEF
) (
  rsfe_cmd_if.sink         cmd,
  output logic             job_valid,
  input  logic             job_ready,
  output rsfe_pkg::job_t   job
);

  localparam int CW = rsfe_pkg::COORD_W;
  localparam logic [CW:0]   W_EXT = (CW + 1)'(FRAME_WIDTH);
  localparam logic [CW:0]   H_EXT = (CW + 1)'(FRAME_HEIGHT);
  localparam logic [CW-1:0] X_MAX = CW'(FRAME_WIDTH - 1);
  localparam logic [CW-1:0] Y_MAX = CW'(FRAME_HEIGHT - 1);

  logic [CW:0]   x_sum, y_sum;
  logic [CW:0]   x_end, y_end;
  logic [CW:0]   x_last, y_last;
  logic [CW-1:0] d_x_lo, d_x_hi, d_y_lo, d_y_hi;
  logic          x_in, y_in;

  assign job_valid = cmd.valid;
  assign cmd.ready = job_ready;

  always_comb begin
    x_sum  = {1'b0, cmd.x_coord} + {1'b0, cmd.span_width};
    y_sum  = {1'b0, cmd.y_coord} + {1'b0, cmd.span_height};
    x_end  = (x_sum > W_EXT) ? W_EXT : x_sum;
    y_end  = (y_sum > H_EXT) ? H_EXT : y_sum;
    x_last = x_end - 1'b1;
    y_last = y_end - 1'b1;
    x_in   = {1'b0, cmd.x_coord} < W_EXT;
    y_in   = {1'b0, cmd.y_coord} < H_EXT;

    // Disc bounding square; low side clipped at zero, high side at the edge
    d_x_lo = (cmd.x_coord > cmd.span_width) ? cmd.x_coord - cmd.span_width : '0;
    d_y_lo = (cmd.y_coord > cmd.span_width) ? cmd.y_coord - cmd.span_width : '0;
    d_x_hi = ({1'b0, cmd.x_coord} + {1'b0, cmd.span_width} > {1'b0, X_MAX}) ?
             X_MAX : cmd.x_coord + cmd.span_width;
    d_y_hi = ({1'b0, cmd.y_coord} + {1'b0, cmd.span_width} > {1'b0, Y_MAX}) ?
             Y_MAX : cmd.y_coord + cmd.span_width;

    job       = '0;
    job.kind  = rsfe_pkg::JOB_NONE;
    job.x_lo  = cmd.x_coord;
    job.x_hi  = cmd.x_coord;
    job.y_lo  = cmd.y_coord;
    job.y_hi  = cmd.y_coord;
    job.cx    = cmd.x_coord;
    job.cy    = cmd.y_coord;
    job.r2    = rsfe_pkg::RSQ_W'(cmd.span_width) * rsfe_pkg::RSQ_W'(cmd.span_width);
    job.paint = cmd.paint;

    case (cmd.mode)
      rsfe_pkg::MODE_PLOT: begin
        if (x_in && y_in) job.kind = rsfe_pkg::JOB_FILL;
      end
      rsfe_pkg::MODE_RECT: begin
        // Empty when the span is zero or the corner lies off the frame
        if (({1'b0, cmd.x_coord} < x_end) && ({1'b0, cmd.y_coord} < y_end)) begin
          job.kind = rsfe_pkg::JOB_FILL;
          job.x_hi = x_last[CW-1:0];
          job.y_hi = y_last[CW-1:0];
        end
      end
      rsfe_pkg::MODE_DISC: begin
        if ((d_x_lo <= d_x_hi) && (d_y_lo <= d_y_hi)) begin
          job.kind = rsfe_pkg::JOB_DISC;
          job.x_lo = d_x_lo;
          job.x_hi = d_x_hi;
          job.y_lo = d_y_lo;
          job.y_hi = d_y_hi;
        end
      end
      rsfe_pkg::MODE_CLEAR: begin
        job.kind = rsfe_pkg::JOB_FILL;
        job.x_lo = '0;
        job.x_hi = X_MAX;
        job.y_lo = '0;
        job.y_hi = Y_MAX;
      end
      rsfe_pkg::MODE_READ: begin
        if (x_in && y_in) job.kind = rsfe_pkg::JOB_READ;
      end
      default: begin
        job.kind = rsfe_pkg::JOB_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/rsfe_queue.sv =====
`default_nettype none

module rsfe_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  rsfe_pkg::job_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output rsfe_pkg::job_t  pop_data
);

  localparam int DEPTH = rsfe_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rsfe_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/rsfe_back.sv =====
`default_nettype none

module rsfe_back #(
  parameter int FRAME_WIDTH  = rsfe_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rsfe_pkg::FRAME_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_pop,
  input  rsfe_pkg::job_t   job,
  rsfe_rsp_if.source       rsp
);

  localparam int CW     = rsfe_pkg::COORD_W;
  localparam int PW     = rsfe_pkg::PIXEL_W;
  localparam int SW     = rsfe_pkg::RSQ_W;
  localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [PW-1:0] mem [DEPTH];

  rsfe_pkg::back_state_t state, state_next;
  rsfe_pkg::job_t        cur;
  logic [CW-1:0]         col, row;
  logic                  load_rsp;

  logic                  s1_valid;
  logic [ADDR_W-1:0]     s1_addr;
  logic [SW-1:0]         s1_dxsq, s1_dysq;
  logic [PW-1:0]         rd_data;

  logic signed [CW:0]     dx, dy;
  logic signed [2*CW+1:0] dx_prod, dy_prod;
  logic [SW:0]            dist_sq;
  logic                   wr_en;

  logic          rsp_valid;
  logic [PW-1:0] rsp_pixel;
  logic          rsp_hit;

  assign rsp.valid      = rsp_valid;
  assign rsp.read_pixel = rsp_pixel;
  assign rsp.read_hit   = rsp_hit;

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    load_rsp   = 1'b0;
    case (state)
      rsfe_pkg::ST_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = (job.kind == rsfe_pkg::JOB_NONE) ? rsfe_pkg::ST_FINISH
                                                       : rsfe_pkg::ST_WALK;
        end
      end
      rsfe_pkg::ST_WALK: begin
        if ((col == cur.x_hi) && (row == cur.y_hi)) state_next = rsfe_pkg::ST_DRAIN;
      end
      rsfe_pkg::ST_DRAIN: begin
        if (!s1_valid) state_next = rsfe_pkg::ST_FINISH;
      end
      rsfe_pkg::ST_FINISH: begin
        if (!rsp_valid || rsp.ready) begin
          load_rsp   = 1'b1;
          state_next = rsfe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rsfe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rsfe_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Raster walker over the clipped bounds, row by row
  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
      col <= job.x_lo;
      row <= job.y_lo;
    end else if (state == rsfe_pkg::ST_WALK) begin
      if (col == cur.x_hi) begin
        col <= cur.x_lo;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_comb begin
    dx      = $signed({1'b0, col}) - $signed({1'b0, cur.cx});
    dy      = $signed({1'b0, row}) - $signed({1'b0, cur.cy});
    dx_prod = dx * dx;
    dy_prod = dy * dy;
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= (state == rsfe_pkg::ST_WALK);
  end

  always_ff @(posedge clk) begin
    if (state == rsfe_pkg::ST_WALK) begin
      s1_addr <= ADDR_W'(row * FRAME_WIDTH) + ADDR_W'(col);
      s1_dxsq <= dx_prod[SW-1:0];
      s1_dysq <= dy_prod[SW-1:0];
    end
  end

  always_comb begin
    dist_sq = {1'b0, s1_dxsq} + {1'b0, s1_dysq};
    wr_en   = (cur.kind == rsfe_pkg::JOB_FILL) ||
              ((cur.kind == rsfe_pkg::JOB_DISC) && (dist_sq <= {1'b0, cur.r2}));
  end

  always_ff @(posedge clk) begin
    if (s1_valid && wr_en) mem[s1_addr] <= cur.paint;
    if (s1_valid && (cur.kind == rsfe_pkg::JOB_READ)) rd_data <= mem[s1_addr];
  end

  // Output register; frees the back end while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_pixel <= (cur.kind == rsfe_pkg::JOB_READ) ? rd_data : '0;
      rsp_hit   <= (cur.kind == rsfe_pkg::JOB_READ);
    end
  end

endmodule

`default_nettype wire

// ===== sv/raster_shape_fill_engine.sv =====
// Flow: a command that touches no pixel goes from IDLE straight to FINISH; one that walks N pixels
//   of its clipped bounding box (1 for plot and read) passes WALK and DRAIN before FINISH.
// Throughput: one command at a time in the back end, set by the one-pixel-per-cycle raster
//   walker over the single frame store write port; a clear walks every pixel of the frame.
// Reset: synchronous, active high; clears queue, walker state and result valid. The frame
//   store is not cleared and holds undefined content until written.
`default_nettype none

module raster_shape_fill_engine #(
  parameter int FRAME_WIDTH  = rsfe_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rsfe_pkg::FRAME_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rsfe_cmd_if.sink    cmd,
  rsfe_rsp_if.source  rsp
);

  // Front end: classify each request into a job with clipped bounds.
  // Queue: two jobs deep, so requests keep flowing while the back end draws.
  // Back end: walk the job area one pixel per cycle, then post one result.

  rsfe_pkg::job_t front_job, back_job;
  logic           front_valid, front_ready;
  logic           back_valid, back_pop;

  rsfe_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .cmd       (cmd),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  rsfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_pop),
    .pop_data   (back_job)
  );

  // Hold each job until its result is posted; drain pixel writes before the
  // next job so a later read sees every earlier write.
  rsfe_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (back_valid),
    .job_pop   (back_pop),
    .job       (back_job),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== sv/rsfe_checker.sv =====
`default_nettype none

module rsfe_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [rsfe_pkg::PIXEL_W-1:0] read_pixel,
  input logic                         read_hit
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(read_pixel) && $stable(read_hit))
    else $error("result changed while stalled");

  a_no_rsp_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("result presented right after reset");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !read_hit |-> read_pixel == '0)
    else $error("nonzero pixel on a result without a read hit");

endmodule

bind raster_shape_fill_engine rsfe_checker u_rsfe_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .read_pixel (rsp.read_pixel),
  .read_hit   (rsp.read_hit)
);

`default_nettype wire

// ===== test/raster_shape_fill_engine_tb.sv =====
`timescale 1ns / 1ps

module raster_shape_fill_engine_tb;

  // Frame geometry matches the parameters the block is built with below
  localparam int FRAME_W = rsfe_pkg::FRAME_WIDTH_DEF;
  localparam int FRAME_H = rsfe_pkg::FRAME_HEIGHT_DEF;
  localparam int FRAME_PIXELS = FRAME_W * FRAME_H;
  localparam int COORD_MAX = (1 << rsfe_pkg::COORD_W) - 1;

  // Mode codes above the last defined one are accepted but do nothing
  localparam int SPARE_MODE_FIRST = int'(rsfe_pkg::MODE_READ) + 1;
  localparam int SPARE_MODE_LAST  = (1 << rsfe_pkg::MODE_W) - 1;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 12;
  // A clear walks the whole frame with no handshake at all, so the stuck
  // limit sits well above FRAME_PIXELS plus the long response hold-off
  localparam int STUCK_LIMIT = 100000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [rsfe_pkg::MODE_W-1:0]  mode;
    logic [rsfe_pkg::COORD_W-1:0] x_coord;
    logic [rsfe_pkg::COORD_W-1:0] y_coord;
    logic [rsfe_pkg::COORD_W-1:0] span_width;
    logic [rsfe_pkg::COORD_W-1:0] span_height;
    logic [rsfe_pkg::PIXEL_W-1:0] paint;
  } draw_cmd_t;

  typedef struct packed {
    logic [rsfe_pkg::PIXEL_W-1:0] pixel;
    logic                         hit;
  } pixel_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rsfe_cmd_if cmd_bus ();
  rsfe_rsp_if rsp_bus ();

  raster_shape_fill_engine #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus.sink),
    .rsp (rsp_bus.source)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the frame store, updated in request order
  bit [rsfe_pkg::PIXEL_W-1:0] frame_model [FRAME_PIXELS];
  // Answers still owed by the block, oldest first
  pixel_answer_t answer_q [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off_request = 0;
  int sent_count = 0;
  int answer_count = 0;
  int fail_count = 0;
  int stuck_cycles = 0;

  // ------------------------------------------------------------------
  // Shadow frame store
  // ------------------------------------------------------------------

  // Write one pixel; drop anything outside the frame
  function automatic void paint_pixel(input int px, input int py,
                                      input bit [rsfe_pkg::PIXEL_W-1:0] colour);
    if (px >= 0 && py >= 0 && px < FRAME_W && py < FRAME_H)
      frame_model[py * FRAME_W + px] = colour;
  endfunction

  // Apply one request to the shadow store and return the answer it owes
  function automatic pixel_answer_t predict_answer(input draw_cmd_t c);
    pixel_answer_t ans;
    int cx, cy, w, h, x_lo, x_hi, y_lo, y_hi, dx, dy;
    ans = '0;
    cx = c.x_coord;
    cy = c.y_coord;
    w = c.span_width;
    h = c.span_height;
    case (c.mode)
      rsfe_pkg::MODE_PLOT: paint_pixel(cx, cy, c.paint);
      rsfe_pkg::MODE_RECT: begin
        // Half-open span, clipped to the frame edge
        x_hi = (cx + w > FRAME_W) ? FRAME_W : cx + w;
        y_hi = (cy + h > FRAME_H) ? FRAME_H : cy + h;
        for (int j = cy; j < y_hi; j++)
          for (int i = cx; i < x_hi; i++)
            paint_pixel(i, j, c.paint);
      end
      rsfe_pkg::MODE_DISC: begin
        // Bounding box centre +/- radius inclusive, negative side clipped at 0
        x_lo = (cx > w) ? cx - w : 0;
        y_lo = (cy > w) ? cy - w : 0;
        x_hi = (cx + w > FRAME_W - 1) ? FRAME_W - 1 : cx + w;
        y_hi = (cy + w > FRAME_H - 1) ? FRAME_H - 1 : cy + w;
        for (int j = y_lo; j <= y_hi; j++)
          for (int i = x_lo; i <= x_hi; i++) begin
            dx = i - cx;
            dy = j - cy;
            if (dx * dx + dy * dy <= w * w)
              paint_pixel(i, j, c.paint);
          end
      end
      rsfe_pkg::MODE_CLEAR: begin
        foreach (frame_model[k])
          frame_model[k] = c.paint;
      end
      rsfe_pkg::MODE_READ: begin
        if (cx < FRAME_W && cy < FRAME_H) begin
          ans.pixel = frame_model[cy * FRAME_W + cx];
          ans.hit = 1'b1;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // ------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------

  function automatic draw_cmd_t make_cmd(input int mode, input int x, input int y,
                                         input int w, input int h,
                                         input bit [rsfe_pkg::PIXEL_W-1:0] paint);
    draw_cmd_t c;
    c.mode = mode[rsfe_pkg::MODE_W-1:0];
    c.x_coord = x[rsfe_pkg::COORD_W-1:0];
    c.y_coord = y[rsfe_pkg::COORD_W-1:0];
    c.span_width = w[rsfe_pkg::COORD_W-1:0];
    c.span_height = h[rsfe_pkg::COORD_W-1:0];
    c.paint = paint;
    return c;
  endfunction

  // Offer one request and return at the edge that accepts it. Valid is left
  // high so that back-to-back requests never lower and raise it in one step.
  task automatic send_command(input draw_cmd_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.mode <= c.mode;
    cmd_bus.x_coord <= c.x_coord;
    cmd_bus.y_coord <= c.y_coord;
    cmd_bus.span_width <= c.span_width;
    cmd_bus.span_height <= c.span_height;
    cmd_bus.paint <= c.paint;
    @(posedge clk);
    while (!cmd_bus.ready)
      @(posedge clk);
    answer_q.push_back(predict_answer(c));
    sent_count++;
  endtask

  // Read back pixels around an anchor, now and then anywhere in the
  // coordinate space (mostly outside the frame). Unused fields get noise.
  task automatic send_probe_reads(input int ax, input int ay, input int ext, input int n);
    int px, py;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        px = $urandom_range(COORD_MAX);
        py = $urandom_range(COORD_MAX);
      end else begin
        px = ax - ext - 1 + int'($urandom_range(2 * ext + 2));
        py = ay - ext - 1 + int'($urandom_range(2 * ext + 2));
        if (px < 0) px = 0;
        if (py < 0) py = 0;
      end
      send_command(make_cmd(rsfe_pkg::MODE_READ, px, py, $urandom_range(COORD_MAX),
                            $urandom_range(COORD_MAX), $urandom()));
    end
  endtask

  // ------------------------------------------------------------------
  // Response side
  // ------------------------------------------------------------------

  // Drive ready: honor a long hold-off when one is asked for, otherwise
  // stall at the current rate
  initial begin : drive_response_ready
    int hold_left;
    hold_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request > 0) begin
        hold_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [rsfe_pkg::PIXEL_W-1:0] got,
                                 input logic [rsfe_pkg::PIXEL_W-1:0] want);
    if (fail_count < MAX_PRINTED)
      $display("MISMATCH answer %0d %s: got %h expected %h", answer_count, what, got, want);
    fail_count++;
  endtask

  // Compare every accepted answer with the oldest one owed
  always @(posedge clk) begin : check_answers
    pixel_answer_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (answer_q.size() == 0) begin
        report_mismatch("with no request pending", rsp_bus.read_pixel, '0);
      end else begin
        want = answer_q.pop_front();
        if (rsp_bus.read_pixel !== want.pixel)
          report_mismatch("read_pixel", rsp_bus.read_pixel, want.pixel);
        if (rsp_bus.read_hit !== want.hit)
          report_mismatch("read_hit", rsp_bus.read_hit, want.hit);
      end
      answer_count++;
    end
  end

  // Stop a run in which no handshake happens for too long
  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Clipping edges, zero sizes, every mode and the spare mode codes. The
  // opening clear makes every pixel written, so later reads are all legal.
  task automatic test_corner_cases();
    send_idle_pct = 0;
    stall_pct = 0;
    send_command(make_cmd(rsfe_pkg::MODE_CLEAR, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_command(make_cmd(rsfe_pkg::MODE_READ, 0, 0, 0, 0, 32'h0));
    send_command(make_cmd(rsfe_pkg::MODE_READ, FRAME_W, 0, 0, 0, 32'h0));
    send_command(make_cmd(rsfe_pkg::MODE_READ, 0, FRAME_H, 0, 0, 32'h0));
    send_command(make_cmd(rsfe_pkg::MODE_PLOT, 0, 0, 0, 0, 32'h1122_3344));
    send_command(make_cmd(rsfe_pkg::MODE_PLOT, FRAME_W - 1, FRAME_H - 1, 0, 0,
                          32'hA5A5_5A5A));
    // plots off the right and bottom edges must not land anywhere
    send_command(make_cmd(rsfe_pkg::MODE_PLOT, FRAME_W, 5, 0, 0, 32'h0));
    send_command(make_cmd(rsfe_pkg::MODE_PLOT, 5, COORD_MAX, 0, 0, 32'h0));
    send_command(make_cmd(rsfe_pkg::MODE_READ, 0, 0, 0, 0, 32'h0));
    send_command(make_cmd(rsfe_pkg::MODE_READ, FRAME_W - 1, FRAME_H - 1, 0, 0, 32'h0));
    // rectangle running off both far edges, then zero width and zero height
    send_command(make_cmd(rsfe_pkg::MODE_RECT, FRAME_W - 8, FRAME_H - 8, COORD_MAX,
                          COORD_MAX, 32'h0000_00FF));
    send_command(make_cmd(rsfe_pkg::MODE_RECT, 10, 10, 0, 5, 32'hDEAD_BEEF));
    send_command(make_cmd(rsfe_pkg::MODE_RECT, 10, 10, 5, 0, 32'hDEAD_BEEF));
    send_command(make_cmd(rsfe_pkg::MODE_READ, FRAME_W - 1, FRAME_H - 8, 0, 0, 32'h0));
    send_command(make_cmd(rsfe_pkg::MODE_READ, 10, 10, 0, 0, 32'h0));
    // zero radius paints the centre only
    send_command(make_cmd(rsfe_pkg::MODE_DISC, 64, 64, 0, 0, 32'h0BAD_F00D));
    send_command(make_cmd(rsfe_pkg::MODE_READ, 64, 64, 0, 0, 32'h0));
    send_command(make_cmd(rsfe_pkg::MODE_READ, 65, 64, 0, 0, 32'h0));
    // disc clipped at 0, and one centred just off the right edge
    send_command(make_cmd(rsfe_pkg::MODE_DISC, 0, 0, 3, COORD_MAX, 32'h1357_9BDF));
    send_command(make_cmd(rsfe_pkg::MODE_READ, 0, 3, 0, 0, 32'h0));
    send_command(make_cmd(rsfe_pkg::MODE_DISC, FRAME_W + 2, 64, 5, 0, 32'h2468_ACE0));
    send_command(make_cmd(rsfe_pkg::MODE_READ, FRAME_W - 1, 64, 0, 0, 32'h0));
    for (int m = SPARE_MODE_FIRST; m <= SPARE_MODE_LAST; m++)
      send_command(make_cmd(m, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                            $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), $urandom()));
  endtask

  // Shapes whose bounding box covers the whole frame, each one walking every pixel
  task automatic test_frame_wide_fills();
    send_idle_pct = 0;
    stall_pct = 0;
    send_command(make_cmd(rsfe_pkg::MODE_RECT, 0, 0, COORD_MAX, COORD_MAX, $urandom()));
    send_probe_reads(FRAME_W / 2, FRAME_H / 2, FRAME_W / 2, 2);
    send_command(make_cmd(rsfe_pkg::MODE_DISC, FRAME_W / 2, FRAME_H / 2, COORD_MAX, 0,
                          $urandom()));
    send_probe_reads(0, 0, 1, 1);
    // far centre with the largest radius: no pixel of the frame is inside
    send_command(make_cmd(rsfe_pkg::MODE_DISC, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          $urandom()));
    send_command(make_cmd(rsfe_pkg::MODE_READ, 0, 0, 0, 0, 32'h0));
    send_command(make_cmd(rsfe_pkg::MODE_READ, FRAME_W - 1, FRAME_H - 1, 0, 0, 32'h0));
    send_command(make_cmd(rsfe_pkg::MODE_READ, 0, FRAME_H - 1, 0, 0, 32'h0));
    send_command(make_cmd(rsfe_pkg::MODE_CLEAR, $urandom_range(COORD_MAX), 0, 0, 0,
                          $urandom()));
    send_probe_reads(FRAME_W / 2, FRAME_H / 2, FRAME_W / 2, 2);
  endtask

  // Draw a random shape, then read back pixels in and around it. A small
  // share is spare mode codes and requests with every field random.
  task automatic test_shape_read_sequences(input int n_items, input int idle_pct,
                                           input int stall_level);
    int first, pick, ax, ay, ext, w, h;
    send_idle_pct = idle_pct;
    stall_pct = stall_level;
    first = sent_count;
    send_command(make_cmd(rsfe_pkg::MODE_CLEAR, 0, 0, 0, 0, $urandom()));
    while (sent_count - first < n_items) begin
      pick = $urandom_range(99);
      ax = $urandom_range(FRAME_W + 7);
      ay = $urandom_range(FRAME_H + 7);
      ext = 1;
      if (pick < 35) begin
        send_command(make_cmd(rsfe_pkg::MODE_PLOT, ax, ay, $urandom_range(COORD_MAX),
                              $urandom_range(COORD_MAX), $urandom()));
      end else if (pick < 60) begin
        if ($urandom_range(3) == 0) begin
          // long thin strip, clipped by the frame
          w = $urandom_range(COORD_MAX);
          h = $urandom_range(3);
          if ($urandom_range(1)) begin
            h = w;
            w = $urandom_range(3);
          end
        end else begin
          w = $urandom_range(8);
          h = $urandom_range(8);
        end
        send_command(make_cmd(rsfe_pkg::MODE_RECT, ax, ay, w, h, $urandom()));
        ext = (w > h) ? w : h;
        if (ext > 12) ext = 12;
      end else if (pick < 85) begin
        ext = $urandom_range(6);
        send_command(make_cmd(rsfe_pkg::MODE_DISC, ax, ay, ext, $urandom_range(COORD_MAX),
                              $urandom()));
      end else if (pick < 90) begin
        send_command(make_cmd($urandom_range(SPARE_MODE_LAST, SPARE_MODE_FIRST),
                              $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                              $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                              $urandom()));
      end else if (pick < 96) begin
        draw_cmd_t wild;
        wild = make_cmd(rsfe_pkg::MODE_PLOT, $urandom_range(COORD_MAX),
                        $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                        $urandom_range(COORD_MAX), $urandom());
        case ($urandom_range(3))
          0: wild.mode = rsfe_pkg::MODE_PLOT;
          1: wild.mode = rsfe_pkg::MODE_RECT;
          2: wild.mode = rsfe_pkg::MODE_DISC;
          default: wild.mode = rsfe_pkg::MODE_READ;
        endcase
        send_command(wild);
        ax = wild.x_coord;
        ay = wild.y_coord;
        ext = 4;
      end
      send_probe_reads(ax, ay, ext, $urandom_range(4, 1));
    end
  endtask

  // Hold the answer side off for a long stretch while requests keep coming,
  // so the queue fills and the block drops its input ready
  task automatic test_output_hold_off();
    int px, py;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off_request = HOLD_OFF_CYCLES;
    for (int k = 0; k < 8; k++) begin
      px = $urandom_range(FRAME_W - 1);
      py = $urandom_range(FRAME_H - 1);
      send_command(make_cmd(rsfe_pkg::MODE_PLOT, px, py, 0, 0, $urandom()));
      send_command(make_cmd(rsfe_pkg::MODE_READ, px, py, 0, 0, 32'h0));
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------

  initial begin
    // every block input known from time zero
    cmd_bus.valid <= 1'b0;
    cmd_bus.mode <= '0;
    cmd_bus.x_coord <= '0;
    cmd_bus.y_coord <= '0;
    cmd_bus.span_width <= '0;
    cmd_bus.span_height <= '0;
    cmd_bus.paint <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_corner_cases();
    test_frame_wide_fills();
    test_shape_read_sequences(130, 0, 0);
    test_shape_read_sequences(130, 63, 0);
    test_shape_read_sequences(130, 0, 63);
    test_shape_read_sequences(130, 30, 30);
    test_output_hold_off();

    cmd_bus.valid <= 1'b0;
    // wait out every owed answer; the stuck-cycle watchdog bounds this
    while (answer_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rsfe_pkg.sv
sv/rsfe_if.sv
sv/rsfe_front.sv
sv/rsfe_queue.sv
sv/rsfe_back.sv
sv/raster_shape_fill_engine.sv
sv/rsfe_checker.sv
test/raster_shape_fill_engine_tb.sv
